[rtl/mm3_pkg.sv]
// ----------------------------------------------------------------------------
// mm3_pkg
// Types, constants and helpers shared by the 128-bit hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package mm3_pkg;

  localparam logic [63:0] MUL_A   = 64'h87c37b91114253d5;
  localparam logic [63:0] MUL_B   = 64'h4cf5ad432745937f;
  localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
  localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
  localparam logic [63:0] FIN_A   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FIN_B   = 64'hc4ceb9fe1a85ec53;

  localparam int BLOCK_BYTES = 16;

  // One block after classification.
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  amount;
    logic        body;
    logic        last;
  } blk_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [63:0] fold33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

`default_nettype wire

[rtl/mm3_front.sv]
// ----------------------------------------------------------------------------
// mm3_front
// Accepts blocks, zeroes tail-block bytes beyond the count, classifies each
// block as body or tail and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [135:0]        s_tdata,  // word_low, word_high, byte_count, zero pad
  input  wire                 s_tlast,
  output logic                q_valid,
  output mm3_pkg::blk_t       q_data,
  input  wire                 q_pop
);
  import mm3_pkg::*;

  blk_t        queue [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [4:0]  nsat;
  logic        body;
  logic [127:0] masked;
  blk_t        entry;
  logic        push;

  always_comb begin
    nsat = (s_tdata[132:128] > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : s_tdata[132:128];
    body = !s_tlast || (nsat == 5'(BLOCK_BYTES));
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      masked[i*8 +: 8] = (body || (5'(i) < nsat)) ? s_tdata[i*8 +: 8] : 8'h00;
    end
    entry.lo     = masked[63:0];
    entry.hi     = masked[127:64];
    entry.amount = body ? 5'(BLOCK_BYTES) : nsat;
    entry.body   = body;
    entry.last   = s_tlast;
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

[rtl/mm3_mul.sv]
// ----------------------------------------------------------------------------
// mm3_mul
// Low 64 bits of a 64 by 64 product, built from three 32 by 32 partial
// products on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_mul (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] a,
  input  wire  [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] p;
  logic [31:0] c;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] prod;

  always_comb begin
    x    = (step == 2'd2) ? a_r[63:32] : a_r[31:0];
    y    = (step == 2'd1) ? b_r[63:32] : b_r[31:0];
    prod = x * y;
  end

  assign done   = busy && (step == 2'd3);
  assign result = p + {c, 32'h0};

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      case (step)
        2'd0: begin
          p <= prod;
        end
        2'd1: begin
          c <= prod[31:0];
        end
        2'd2: begin
          c <= c + prod[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      step <= step + 2'd1;
      if (step == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mm3_back.sv]
// ----------------------------------------------------------------------------
// mm3_back
// Sequencer that runs the body mix, tail mix and finalization on queued
// blocks, sharing one multi-cycle multiplier, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mm3_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  input  mm3_pkg::blk_t       q_data,
  output logic                q_pop,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [127:0]        m_tdata
);
  import mm3_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_K1A  = 4'd1;
  localparam logic [3:0] ST_K1B  = 4'd2;
  localparam logic [3:0] ST_H1   = 4'd3;
  localparam logic [3:0] ST_K2A  = 4'd4;
  localparam logic [3:0] ST_K2B  = 4'd5;
  localparam logic [3:0] ST_H2   = 4'd6;
  localparam logic [3:0] ST_FX   = 4'd7;
  localparam logic [3:0] ST_FS1  = 4'd8;
  localparam logic [3:0] ST_FS2  = 4'd9;
  localparam logic [3:0] ST_M1A  = 4'd10;
  localparam logic [3:0] ST_M1B  = 4'd11;
  localparam logic [3:0] ST_M2A  = 4'd12;
  localparam logic [3:0] ST_M2B  = 4'd13;
  localparam logic [3:0] ST_FS3  = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  logic [3:0]  state;
  logic        issued;
  blk_t        cur;
  logic [63:0] h1;
  logic [63:0] h2;
  logic [63:0] total;
  logic [63:0] k;
  logic        mul_state;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] r;
  logic        out_load;

  mm3_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (r)
  );

  always_comb begin
    mul_state = 1'b1;
    mul_a     = cur.lo;
    mul_b     = MUL_A;
    case (state)
      ST_K1A: begin
        mul_a = cur.lo;
        mul_b = MUL_A;
      end
      ST_K1B: begin
        mul_a = rotl64(k, 31);
        mul_b = MUL_B;
      end
      ST_K2A: begin
        mul_a = cur.hi;
        mul_b = MUL_B;
      end
      ST_K2B: begin
        mul_a = rotl64(k, 33);
        mul_b = MUL_A;
      end
      ST_M1A: begin
        mul_a = fold33(h1);
        mul_b = FIN_A;
      end
      ST_M1B: begin
        mul_a = fold33(k);
        mul_b = FIN_B;
      end
      ST_M2A: begin
        mul_a = fold33(h2);
        mul_b = FIN_A;
      end
      ST_M2B: begin
        mul_a = fold33(k);
        mul_b = FIN_B;
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
  end

  assign mul_start = mul_state && !issued;
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign out_load  = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (out_load) begin
      m_tdata <= {h2 + h1, h1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issued   <= 1'b0;
      h1       <= 64'h0;
      h2       <= 64'h0;
      total    <= 64'h0;
      k        <= 64'h0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            total <= total + 64'(q_data.amount);
            state <= ST_K1A;
          end
        end
        ST_K1A: begin
          if (mul_done) begin
            k     <= r;
            state <= ST_K1B;
          end
        end
        ST_K1B: begin
          if (mul_done) begin
            if (cur.body) begin
              h1    <= rotl64(h1 ^ r, 27) + h2;
              state <= ST_H1;
            end else begin
              h1    <= h1 ^ r;
              state <= ST_K2A;
            end
          end
        end
        ST_H1: begin
          h1    <= h1 + (h1 << 2) + ADD_ONE;
          state <= ST_K2A;
        end
        ST_K2A: begin
          if (mul_done) begin
            k     <= r;
            state <= ST_K2B;
          end
        end
        ST_K2B: begin
          if (mul_done) begin
            if (cur.body) begin
              h2    <= rotl64(h2 ^ r, 31) + h1;
              state <= ST_H2;
            end else begin
              h2    <= h2 ^ r;
              state <= cur.last ? ST_FX : ST_IDLE;
            end
          end
        end
        ST_H2: begin
          h2    <= h2 + (h2 << 2) + ADD_TWO;
          state <= cur.last ? ST_FX : ST_IDLE;
        end
        ST_FX: begin
          h1    <= h1 ^ total;
          h2    <= h2 ^ total;
          state <= ST_FS1;
        end
        ST_FS1: begin
          h1    <= h1 + h2;
          state <= ST_FS2;
        end
        ST_FS2: begin
          h2    <= h2 + h1;
          state <= ST_M1A;
        end
        ST_M1A: begin
          if (mul_done) begin
            k     <= r;
            state <= ST_M1B;
          end
        end
        ST_M1B: begin
          if (mul_done) begin
            h1    <= fold33(r);
            state <= ST_M2A;
          end
        end
        ST_M2A: begin
          if (mul_done) begin
            k     <= r;
            state <= ST_M2B;
          end
        end
        ST_M2B: begin
          if (mul_done) begin
            h2    <= fold33(r);
            state <= ST_FS3;
          end
        end
        ST_FS3: begin
          h1    <= h1 + h2;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            h1       <= 64'h0;
            h2       <= 64'h0;
            total    <= 64'h0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/murmur3_128_hash_core.sv]
// ----------------------------------------------------------------------------
// murmur3_128_hash_core
// 128-bit MurmurHash3 (x64 variant, zero seed) over a stream of 16-byte blocks.
// ----------------------------------------------------------------------------
// Each input item is one block; the item marked with tlast ends the key and
// may carry 0 to 16 valid bytes, and one 128-bit hash item follows it. The
// back end's pace through mixing and finalization is set by the single
// shared 32 by 32 multiplier, which makes three passes for each of the four
// 64-bit products per block. A two-entry queue lets the next blocks be
// accepted while one is being mixed, and a finished hash waits in an output
// register without stopping work on the next key until that key's own hash
// is ready.
`default_nettype none

module murmur3_128_hash_core (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [135:0] s_tdata,   // word_low, word_high, byte_count, zero pad
  input  wire          s_tlast,   // last
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [127:0] m_tdata    // hash_low, hash_high
);
  import mm3_pkg::*;

  logic q_valid;
  blk_t q_data;
  logic q_pop;

  mm3_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  mm3_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
